### rtl/ptts_pkg.sv
// shared types, constants and helpers for the priority timer task scheduler
// no dependencies
`timescale 1ns / 1ps
package ptts_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TOTAL_W     = 7;
  localparam int COUNT_W     = 5;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 16;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [7:0]  ident;
    logic [7:0]  prio;
    logic [31:0] deadline;
    logic [23:0] period;
    logic [15:0] remaining;
  } entry_t;

  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

### rtl/ptts_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ptts_head_scan.sv
// head search: keeps the best entry seen during a sweep of the task ram
// depends on ptts_pkg
`timescale 1ns / 1ps
module ptts_head_scan #(
  parameter int TABLE_DEPTH = ptts_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           cmp_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] cmp_idx,
  input  logic                           cmp_valid,
  input  ptts_pkg::entry_t               cmp_rec,
  output logic                           found,
  output logic [$clog2(TABLE_DEPTH)-1:0] best_idx,
  output ptts_pkg::entry_t               best_rec
);

  logic better;

  always_comb begin
    better = !found || (cmp_rec.prio < best_rec.prio) ||
             ((cmp_rec.prio == best_rec.prio) &&
              ptts_pkg::earlier(cmp_rec.deadline, best_rec.deadline));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
    end else if (cmp_en && cmp_valid && better) begin
      found    <= 1'b1;
      best_idx <= cmp_idx;
      best_rec <= cmp_rec;
    end
  end

endmodule

### rtl/priority_timer_task_scheduler.sv
// priority timer task scheduler: task table in ram, valid bits in flops
// insert and clear go through the exec state; a tick sweeps the ram once for the head search,
// then once more after each firing, each sweep followed by a settle and a decide state
// one word in work at a time; the output register holds one result word
// synchronous reset empties the table and zeroes the clock, no clearing pass
// depends on ptts_pkg, ptts_ram, ptts_head_scan
`timescale 1ns / 1ps
module priority_timer_task_scheduler #(
  parameter int TABLE_DEPTH = ptts_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // task_ident, delay_ms, repeat_total, prio_level
  input  logic [ptts_pkg::IN_DATA_W-1:0] s_tdata,
  // req_type
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // fired_ident, insert_status, pending_count, zero pad
  output logic [ptts_pkg::OUT_DATA_W-1:0] m_tdata,
  // fired
  output logic                           m_tuser,
  output logic                           m_tlast
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int LIMIT = (TABLE_DEPTH < ptts_pkg::MAX_RESULTS) ? TABLE_DEPTH
                                                                : ptts_pkg::MAX_RESULTS;
  localparam int NW    = $clog2(LIMIT + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_SETTLE, S_DECIDE} state_t;

  state_t                       state;
  logic [1:0]                   req;
  ptts_pkg::entry_t             in_rec;
  logic [31:0]                  now;
  logic [ptts_pkg::TOTAL_W-1:0] total;
  logic [TABLE_DEPTH-1:0]       valid;
  logic [IW-1:0]                ridx;
  logic [NW-1:0]                nfire;
  logic                         pend;
  logic [7:0]                   pend_ident;
  logic [ptts_pkg::TOTAL_W-1:0] pend_count;
  logic                         cmp_en;
  logic [IW-1:0]                cmp_idx;
  logic                         scan_start;

  logic                         out_fired;
  logic [7:0]                   out_ident;
  logic                         out_status;
  logic [ptts_pkg::COUNT_W-1:0] out_count;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  ptts_pkg::entry_t             ram_wdata;
  ptts_pkg::entry_t             ram_rdata;

  logic                         found;
  logic [IW-1:0]                best_idx;
  ptts_pkg::entry_t             best_rec;

  logic                         out_free;
  logic                         full;
  logic [IW-1:0]                free_slot;
  logic                         due;
  logic [15:0]                  rem_next;
  ptts_pkg::entry_t             fire_rec;
  logic                         do_insert;
  logic                         do_fire;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = &valid;
  assign m_tuser  = out_fired;
  assign m_tdata  = {2'b00, out_count, out_status, out_ident};

  always_comb begin
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  always_comb begin
    due = found && !ptts_pkg::earlier(now, best_rec.deadline) &&
          (nfire < NW'(LIMIT));
    rem_next = (best_rec.remaining != 16'd0) ? best_rec.remaining - 16'd1 : 16'd0;
    fire_rec = best_rec;
    fire_rec.remaining = rem_next;
    fire_rec.deadline  = now + {8'd0, best_rec.period};
    do_insert = (state == S_EXEC) && out_free && (req == ptts_pkg::REQ_INSERT) && !full;
    do_fire   = (state == S_DECIDE) && due && (!pend || out_free);
    ram_we    = do_insert || do_fire;
    ram_waddr = do_fire ? best_idx : free_slot;
    ram_wdata = in_rec;
    ram_wdata.deadline = now + {8'd0, in_rec.period};
    if (do_fire) begin
      ram_wdata = fire_rec;
    end
  end

  ptts_ram #(
    .WIDTH($bits(ptts_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ridx),
    .rdata(ram_rdata)
  );

  ptts_head_scan #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .cmp_en   (cmp_en),
    .cmp_idx  (cmp_idx),
    .cmp_valid(valid[cmp_idx]),
    .cmp_rec  (ram_rdata),
    .found    (found),
    .best_idx (best_idx),
    .best_rec (best_rec)
  );

  always_ff @(posedge clk) begin
    cmp_idx <= ridx;
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      total      <= '0;
      valid      <= '0;
      ridx       <= '0;
      nfire      <= '0;
      pend       <= 1'b0;
      cmp_en     <= 1'b0;
      scan_start <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      cmp_en     <= (state == S_SCAN);
      scan_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req              <= s_tuser;
            in_rec.ident     <= s_tdata[7:0];
            in_rec.period    <= s_tdata[31:8];
            in_rec.remaining <= s_tdata[47:32];
            in_rec.prio      <= s_tdata[55:48];
            in_rec.deadline  <= '0;
            if (s_tuser == ptts_pkg::REQ_TICK) begin
              now        <= now + 32'd1;
              ridx       <= '0;
              nfire      <= '0;
              pend       <= 1'b0;
              scan_start <= 1'b1;
              state      <= S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tlast    <= 1'b1;
            out_fired  <= 1'b0;
            out_ident  <= 8'd0;
            out_status <= 1'b0;
            out_count  <= total[ptts_pkg::COUNT_W-1:0];
            if (req == ptts_pkg::REQ_INSERT) begin
              if (full) begin
                out_status <= 1'b1;
              end else begin
                valid[free_slot] <= 1'b1;
                total            <= total + 1'b1;
                out_count        <= ptts_pkg::COUNT_W'(total + 1'b1);
              end
            end else if (req == ptts_pkg::REQ_CLEAR) begin
              valid     <= '0;
              total     <= '0;
              out_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (ridx == IW'(TABLE_DEPTH - 1)) begin
            state <= S_SETTLE;
          end else begin
            ridx <= ridx + 1'b1;
          end
        end
        S_SETTLE: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (pend || !due) begin
            if (out_free) begin
              m_tvalid   <= 1'b1;
              m_tlast    <= !due;
              out_fired  <= pend;
              out_ident  <= pend ? pend_ident : 8'd0;
              out_status <= 1'b0;
              out_count  <= pend ? pend_count[ptts_pkg::COUNT_W-1:0]
                                 : total[ptts_pkg::COUNT_W-1:0];
              if (!due) begin
                pend  <= 1'b0;
                state <= S_IDLE;
              end
            end
          end
          if (do_fire) begin
            pend       <= 1'b1;
            pend_ident <= best_rec.ident;
            nfire      <= nfire + 1'b1;
            if (rem_next == 16'd0) begin
              valid[best_idx] <= 1'b0;
              total           <= total - 1'b1;
              pend_count      <= total - 1'b1;
            end else begin
              pend_count <= total;
            end
            ridx       <= '0;
            scan_start <= 1'b1;
            state      <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ptts_checker.sv
// port-level checks for the priority timer task scheduler, bound to the top level
// depends on priority_timer_task_scheduler
`timescale 1ns / 1ps
module ptts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_ident_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("ident set on a word with no firing");

  a_not_last_fires: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final word is not a firing");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> !m_tuser && m_tlast)
    else $error("dropped insert word is not a lone result");

endmodule

bind priority_timer_task_scheduler ptts_checker u_ptts_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

### verif/tb_top.sv
// testbench for the priority timer task scheduler: directed and random requests
// checked against an in-bench task table model through a small scoreboard class
// depends on ptts_pkg and priority_timer_task_scheduler
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH = ptts_pkg::DEPTH_DEF;
  localparam int WATCHDOG_MAX = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic       fired;
    logic [7:0] ident;
    logic       status;
    logic [4:0] count;
    logic       last;
  } sched_word_t;

  int mismatch_count = 0;

  task automatic report(input string what, input sched_word_t got, input sched_word_t exp);
    $display({"mismatch %s: got f=%0d id=%0d st=%0d n=%0d l=%0d",
              " exp f=%0d id=%0d st=%0d n=%0d l=%0d"},
             what, got.fired, got.ident, got.status, got.count, got.last,
             exp.fired, exp.ident, exp.status, exp.count, exp.last);
    mismatch_count++;
  endtask

  class sched_scoreboard;
    logic        valid [DEPTH];
    logic [7:0]  prio [DEPTH];
    logic [31:0] deadline [DEPTH];
    logic [23:0] period [DEPTH];
    logic [15:0] remaining [DEPTH];
    logic [7:0]  ident [DEPTH];
    logic [31:0] now;
    logic [4:0]  total;
    sched_word_t pending_words [$];

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      now = '0;
      total = '0;
    endfunction

    function bit is_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function int head_slot();
      int best;
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (valid[i] && (best < 0 || prio[i] < prio[best] ||
            (prio[i] == prio[best] && is_before(deadline[i], deadline[best]))))
          best = i;
      return best;
    endfunction

    function void push(logic f, logic [7:0] id, logic st, logic l);
      sched_word_t w;
      w.fired = f; w.ident = id; w.status = st; w.count = total; w.last = l;
      pending_words.push_back(w);
    endfunction

    function void note_request(logic [1:0] req, logic [7:0] id, logic [23:0] dly,
                               logic [15:0] rep, logic [7:0] pr);
      int slot, n, h;
      if (req == ptts_pkg::REQ_INSERT) begin
        slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) if (!valid[i]) slot = i;
        if (slot < 0) begin
          push(1'b0, 8'd0, 1'b1, 1'b1);
        end else begin
          valid[slot] = 1'b1; ident[slot] = id; period[slot] = dly;
          remaining[slot] = rep; prio[slot] = pr;
          deadline[slot] = now + 32'(dly);
          total++;
          push(1'b0, 8'd0, 1'b0, 1'b1);
        end
      end else if (req == ptts_pkg::REQ_TICK) begin
        now++;
        n = 0;
        while (n < DEPTH) begin
          h = head_slot();
          if (h < 0 || is_before(now, deadline[h])) break;
          if (remaining[h] > 0) remaining[h]--;
          if (remaining[h] > 0) begin
            deadline[h] = now + 32'(period[h]);
          end else begin
            valid[h] = 1'b0;
            total--;
          end
          push(1'b1, ident[h], 1'b0, 1'b0);
          n++;
        end
        if (n == 0) push(1'b0, 8'd0, 1'b0, 1'b1);
        else pending_words[$].last = 1'b1;
      end else begin
        if (req == ptts_pkg::REQ_CLEAR) begin
          foreach (valid[i]) valid[i] = 1'b0;
          total = '0;
        end
        push(1'b0, 8'd0, 1'b0, 1'b1);
      end
    endfunction

    task check_word(sched_word_t got);
      sched_word_t exp;
      if (pending_words.size() == 0) begin
        report("unexpected word", got, got);
        return;
      end
      exp = pending_words.pop_front();
      if (got.fired !== exp.fired) report("fired", got, exp);
      if (got.ident !== exp.ident) report("fired_ident", got, exp);
      if (got.status !== exp.status) report("insert_status", got, exp);
      if (got.count !== exp.count) report("pending_count", got, exp);
      if (got.last !== exp.last) report("last_of_run", got, exp);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ptts_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ptts_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  priority_timer_task_scheduler #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  sched_scoreboard sb = new();
  bit sender_done = 1'b0;
  bit rx_hold = 1'b0;
  int idle_cycles = 0;

  // issue one request word, with an optional random gap first
  task automatic send(input logic [1:0] req, input logic [7:0] id, input logic [23:0] dly,
                      input logic [15:0] rep, input logic [7:0] pr, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {pr, rep, dly, id};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, id, dly, rep, pr);
  endtask

  task automatic send_noise(input logic [1:0] req);
    send(req, 8'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic rand_insert(input int max_delay, input int max_rep);
    send(ptts_pkg::REQ_INSERT, 8'($urandom), 24'($urandom_range(0, max_delay)),
         16'($urandom_range(0, max_rep)), 8'($urandom_range(0, 7)));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready)
        sb.check_word({m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[13:9], m_tlast});
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stalls per word, a long hold-off when asked
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 9) < 3) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every request kind, full table, zero period, firing cap
    send(ptts_pkg::REQ_TICK, 8'd0, 24'd0, 16'd0, 8'd0);
    send(ptts_pkg::REQ_INSERT, 8'hff, 24'hffffff, 16'hffff, 8'hff);
    send(ptts_pkg::REQ_INSERT, 8'h00, 24'd0, 16'd0, 8'h00);
    send(ptts_pkg::REQ_INSERT, 8'h5a, 24'd0, 16'd3, 8'h00);
    send(ptts_pkg::REQ_TICK, 8'd0, 24'd0, 16'd0, 8'd0);
    send(REQ_UNUSED, 8'haa, 24'h123456, 16'h5555, 8'h55);
    send(ptts_pkg::REQ_CLEAR, 8'd0, 24'd0, 16'd0, 8'd0);
    for (int i = 0; i < 17; i++)
      send(ptts_pkg::REQ_INSERT, 8'(i), 24'(i % 2), 16'(i % 3), 8'(i % 4), 1'b0);
    send(ptts_pkg::REQ_TICK, 8'd0, 24'd0, 16'd0, 8'd0);
    send(ptts_pkg::REQ_TICK, 8'd0, 24'd0, 16'd0, 8'd0);
    send(ptts_pkg::REQ_CLEAR, 8'hff, 24'hffffff, 16'hffff, 8'hff);

    // random: a mix of inserts with short or long delays, ticks, clears and unused requests
    for (int k = 0; k < 250; ) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (k == 120) rx_hold = 1'b1;
      if (pick < 35) rand_insert(6, 4);
      else if (pick < 40) rand_insert(24'hffffff, 65535);
      else if (pick < 93) send_noise(ptts_pkg::REQ_TICK);
      else if (pick < 97) send_noise(ptts_pkg::REQ_CLEAR);
      else send_noise(REQ_UNUSED);
      k++;
    end
    s_tvalid <= 1'b0;
    sender_done = 1'b1;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
